FILE: rtl/asgr_pkg.sv
package asgr_pkg;

	localparam int unsigned PARAM_W   = 10;
	localparam logic [PARAM_W-1:0] PARAM_MAX = 10'd1023;

	localparam logic [7:0] BYTE_ESC   = 8'h1B;
	localparam logic [7:0] BYTE_LBRK  = 8'h5B;
	localparam logic [7:0] BYTE_FINAL = 8'h6D;
	localparam logic [7:0] BYTE_SEP   = 8'h3B;
	localparam logic [7:0] BYTE_D0    = 8'd48;
	localparam logic [7:0] BYTE_D9    = 8'd57;

	localparam logic [1:0] WEIGHT_NORMAL = 2'd0;
	localparam logic [1:0] WEIGHT_BOLD   = 2'd1;
	localparam logic [1:0] WEIGHT_FAINT  = 2'd2;
	localparam logic [3:0] COLOR_DEFAULT = 4'd8;

	localparam logic [PARAM_W-1:0] SGR_RESET      = 10'd0;
	localparam logic [PARAM_W-1:0] SGR_BOLD       = 10'd1;
	localparam logic [PARAM_W-1:0] SGR_FAINT      = 10'd2;
	localparam logic [PARAM_W-1:0] SGR_ITALIC     = 10'd3;
	localparam logic [PARAM_W-1:0] SGR_UNDERLINE  = 10'd4;
	localparam logic [PARAM_W-1:0] SGR_WEIGHT_OFF = 10'd22;
	localparam logic [PARAM_W-1:0] SGR_ITALIC_OFF = 10'd23;
	localparam logic [PARAM_W-1:0] SGR_UL_OFF     = 10'd24;
	localparam logic [PARAM_W-1:0] SGR_FG_LO      = 10'd30;
	localparam logic [PARAM_W-1:0] SGR_FG_HI      = 10'd37;
	localparam logic [PARAM_W-1:0] SGR_BG_LO      = 10'd40;
	localparam logic [PARAM_W-1:0] SGR_BG_HI      = 10'd47;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ESC   = 2'd1,
		PH_PARAM = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0] weight;
		logic       italic;
		logic       underline;
		logic [3:0] fg;
		logic [3:0] bg;
	} style_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] char_out;
		logic       style_changed;
		logic       seq_error;
		style_t     style;
	} result_t;

	localparam style_t STYLE_RESET = '{
		weight:    WEIGHT_NORMAL,
		italic:    1'b0,
		underline: 1'b0,
		fg:        COLOR_DEFAULT,
		bg:        COLOR_DEFAULT
	};

	function automatic style_t apply_code(style_t cur, logic [PARAM_W-1:0] code);
		style_t nxt;
		nxt = cur;
		case (code) inside
			SGR_RESET:              nxt = STYLE_RESET;
			SGR_BOLD:               nxt.weight = WEIGHT_BOLD;
			SGR_FAINT:              nxt.weight = WEIGHT_FAINT;
			SGR_ITALIC:             nxt.italic = 1'b1;
			SGR_UNDERLINE:          nxt.underline = 1'b1;
			SGR_WEIGHT_OFF:         nxt.weight = WEIGHT_NORMAL;
			SGR_ITALIC_OFF:         nxt.italic = 1'b0;
			SGR_UL_OFF:             nxt.underline = 1'b0;
			[SGR_FG_LO:SGR_FG_HI]:  nxt.fg = {1'b0, 3'(code - SGR_FG_LO)};
			[SGR_BG_LO:SGR_BG_HI]:  nxt.bg = {1'b0, 3'(code - SGR_BG_LO)};
			default:                nxt = cur;
		endcase
		return nxt;
	endfunction

endpackage

FILE: rtl/asgr_core.sv
module asgr_core import asgr_pkg::*; #(
	parameter int unsigned MAX_SEQ_LEN = 21
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] byte_s1,
	input  logic       ansi_enabled,
	output result_t    res
);

	localparam int unsigned LEN_W = $clog2(MAX_SEQ_LEN + 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_SEQ_LEN);

	phase_t             phase_q, phase_n;
	logic [PARAM_W-1:0] param_q, param_n;
	logic [LEN_W-1:0]   len_q, len_n;
	style_t             style_q, style_n;

	logic               is_digit, is_final, is_sep, too_long;
	logic [13:0]        acc;
	logic [PARAM_W-1:0] param_sat;
	style_t             style_app;

	assign is_digit  = (byte_s1 >= BYTE_D0) && (byte_s1 <= BYTE_D9);
	assign is_final  = (byte_s1 == BYTE_FINAL);
	assign is_sep    = (byte_s1 == BYTE_SEP);
	assign too_long  = (len_q >= LEN_MAX);
	assign acc       = 14'({4'b0, param_q} * 14'd10) + {10'b0, byte_s1[3:0]};
	assign param_sat = (acc > {4'b0, PARAM_MAX}) ? PARAM_MAX : acc[PARAM_W-1:0];
	assign style_app = apply_code(style_q, param_q);

	// next phase
	always_comb begin
		phase_n = PH_IDLE;
		case (phase_q)
			PH_ESC: begin
				phase_n = (byte_s1 == BYTE_LBRK) ? PH_PARAM : PH_IDLE;
			end
			PH_PARAM: begin
				if ((is_digit || is_sep) && !too_long)
					phase_n = PH_PARAM;
				else
					phase_n = PH_IDLE;
			end
			default: begin
				phase_n = (byte_s1 == BYTE_ESC && ansi_enabled) ? PH_ESC : PH_IDLE;
			end
		endcase
	end

	// datapath and result
	always_comb begin
		param_n = '0;
		len_n   = '0;
		style_n = style_q;
		res     = '0;
		case (phase_q)
			PH_ESC: begin
				if (byte_s1 == BYTE_LBRK) begin
					len_n = LEN_W'(2);
				end else begin
					res.style_changed = 1'b1;
					res.seq_error     = 1'b1;
				end
			end
			PH_PARAM: begin
				if (is_digit) begin
					if (too_long) begin
						res.style_changed = 1'b1;
						res.seq_error     = 1'b1;
					end else begin
						param_n = param_sat;
						len_n   = len_q + 1'b1;
					end
				end else if (is_final) begin
					style_n           = style_app;
					res.style_changed = 1'b1;
				end else if (is_sep) begin
					style_n = style_app;
					if (too_long) begin
						res.style_changed = 1'b1;
						res.seq_error     = 1'b1;
					end else begin
						len_n = len_q + 1'b1;
					end
				end else begin
					res.style_changed = 1'b1;
					res.seq_error     = 1'b1;
				end
			end
			default: begin
				if (byte_s1 == BYTE_ESC && ansi_enabled) begin
					len_n = LEN_W'(1);
				end else begin
					res.char_valid = 1'b1;
					res.char_out   = byte_s1;
				end
			end
		endcase
		res.style = style_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			param_q <= '0;
			len_q   <= '0;
			style_q <= STYLE_RESET;
		end else if (advance) begin
			phase_q <= phase_n;
			param_q <= param_n;
			len_q   <= len_n;
			style_q <= style_n;
		end
	end

endmodule

FILE: rtl/asgr_out_stage.sv
module asgr_out_stage import asgr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	input  logic    out_ready,
	output logic    out_valid,
	output result_t res_s2
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

endmodule

FILE: rtl/ansi_sgr_style_decoder_unit.sv
// ANSI SGR style decoder. Feed a text stream one byte per word on the input
// channel; each byte gives exactly one result word. Plain bytes come out with
// char_valid set and the current style (weight, italic, underline, foreground
// and background color, 8 meaning default). Bytes of an escape ESC [ n;n... m
// are swallowed (char_valid low); each parameter takes effect on its ';' or
// the final 'm'. style_changed marks the byte that ended an escape, and
// seq_error marks an escape cut short by a wrong second byte, a bad parameter
// byte or more than MAX_SEQ_LEN bytes before the final 'm'. Write cfg_data
// with cfg_we high to set ansi_enabled (reset 1); with it low ESC passes as
// text. Only write it while no bytes are in flight. Throughput is one byte per
// cycle while out_ready keeps the result register draining: the parser state
// and style update from the input register, so the next byte sees them at
// once. A byte passes through the input register, then the result register,
// before its result word appears. While out_ready is low the result register
// holds its word, and in_ready drops once the input register is full as well.
module ansi_sgr_style_decoder_unit import asgr_pkg::*; #(
	parameter int unsigned MAX_SEQ_LEN = 21
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       char_valid,
	output logic [7:0] char_out,
	output logic       style_changed,
	output logic       seq_error,
	output logic [1:0] weight_out,
	output logic       italic_out,
	output logic       underline_out,
	output logic [3:0] fg_out,
	output logic [3:0] bg_out
);

	logic       ansi_enabled_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	result_t    res;
	result_t    res_s2;

	// advance the held byte whenever the result register is free or draining
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ansi_enabled_q <= 1'b1;
		end else if (cfg_we) begin
			ansi_enabled_q <= cfg_data;
		end
	end

	// input register: hold the byte until the parser takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
		end
	end

	// parser state and style, updated once per byte
	asgr_core #(
		.MAX_SEQ_LEN (MAX_SEQ_LEN)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.byte_s1      (byte_s1),
		.ansi_enabled (ansi_enabled_q),
		.res          (res)
	);

	// result register: hold the word until the sink takes it
	asgr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res_s2    (res_s2)
	);

	assign char_valid    = res_s2.char_valid;
	assign char_out      = res_s2.char_out;
	assign style_changed = res_s2.style_changed;
	assign seq_error     = res_s2.seq_error;
	assign weight_out    = res_s2.style.weight;
	assign italic_out    = res_s2.style.italic;
	assign underline_out = res_s2.style.underline;
	assign fg_out        = res_s2.style.fg;
	assign bg_out        = res_s2.style.bg;

endmodule
